// File: rtl/core/lidar_point_polar_to_xy_assert.svh
// Assertion macros used by the checker of the lidar point converter
`ifndef LIDAR_POINT_POLAR_TO_XY_ASSERT_SVH
`define LIDAR_POINT_POLAR_TO_XY_ASSERT_SVH

// Same-cycle implication, off while reset is low
`define LPPXY_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("lppxy assertion failed");

// Next-cycle implication, off while reset is low
`define LPPXY_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("lppxy assertion failed");

// Next-cycle implication that also holds through reset
`define LPPXY_ASSERT_NEXT_ALWAYS(label, clk, pre, post) \
    label: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("lppxy assertion failed");

`endif

// File: rtl/core/lppxy_pkg.sv
// Types, widths and constants of the lidar point converter
package lppxy_pkg;

    localparam int ANG_W  = 16;   // angle code
    localparam int DIST_W = 18;   // distance code and range gates
    localparam int OUT_W  = 19;   // x / y result
    localparam int GAIN_W = 32;   // inverse CORDIC gain, Q32
    localparam int P_W    = DIST_W + GAIN_W;
    localparam int XW     = 53;   // CORDIC x / y datapath
    localparam int ZW     = 33;   // residual angle, 2^32 per turn
    localparam int RND_W  = XW - 32;

    localparam logic [63:0] INV_GAIN_C = 64'h0000_0000_9B74_EDA8;

    localparam logic signed [RND_W-1:0] OUT_LIMIT_POS = RND_W'(262143);
    localparam logic signed [RND_W-1:0] OUT_LIMIT_NEG = -RND_W'(262143);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 1'd1;

    localparam logic [DIST_W-1:0] MIN_DISTANCE_RST = 18'd400;
    localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 18'd24000;

    // quadrant of the start vector
    localparam logic [1:0] QUAD_POS_X = 2'd0;
    localparam logic [1:0] QUAD_POS_Y = 2'd1;
    localparam logic [1:0] QUAD_NEG_X = 2'd2;
    localparam logic [1:0] QUAD_NEG_Y = 2'd3;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_vec;

    // atan(2^-i) in turns, Q32
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] a;
        case (idx)
            0:       a = 32'h2000_0000;
            1:       a = 32'h12E4_051E;
            2:       a = 32'h09FB_385B;
            3:       a = 32'h0511_11D4;
            4:       a = 32'h028B_0D43;
            5:       a = 32'h0145_D7E1;
            6:       a = 32'h00A2_F61E;
            7:       a = 32'h0051_7C55;
            8:       a = 32'h0028_BE53;
            9:       a = 32'h0014_5F2F;
            10:      a = 32'h000A_2F98;
            11:      a = 32'h0005_17CC;
            12:      a = 32'h0002_8BE6;
            13:      a = 32'h0001_45F3;
            14:      a = 32'h0000_A2FA;
            15:      a = 32'h0000_517D;
            16:      a = 32'h0000_28BE;
            17:      a = 32'h0000_145F;
            18:      a = 32'h0000_0A30;
            19:      a = 32'h0000_0518;
            20:      a = 32'h0000_028C;
            21:      a = 32'h0000_0146;
            22:      a = 32'h0000_00A3;
            23:      a = 32'h0000_0051;
            default: a = 32'h0000_0000;
        endcase
        return a;
    endfunction

endpackage

// File: rtl/core/lppxy_pt_if.sv
// Valid/ready channel carrying one polar lidar point
interface lppxy_pt_if;
    logic                         valid;
    logic                         ready;
    logic [lppxy_pkg::ANG_W-1:0]  angle_code;
    logic [lppxy_pkg::DIST_W-1:0] distance_code;

    modport source (output valid, output angle_code, output distance_code, input ready);
    modport sink   (input valid, input angle_code, input distance_code, output ready);
endinterface

// File: rtl/core/lppxy_xy_if.sv
// Valid/ready channel carrying one cartesian point
interface lppxy_xy_if;
    logic                               valid;
    logic                               ready;
    logic signed [lppxy_pkg::OUT_W-1:0] x_pos;
    logic signed [lppxy_pkg::OUT_W-1:0] y_pos;

    modport source (output valid, output x_pos, output y_pos, input ready);
    modport sink   (input valid, input x_pos, input y_pos, output ready);
endinterface

// File: rtl/core/lidar_point_polar_to_xy.sv
// Top level of the lidar polar-to-cartesian point converter
//
//  channel   | dir | transfer contents              | handshake
//  ----------+-----+--------------------------------+--------------------------
//  i_pt      | in  | angle_code, distance_code      | valid/ready
//  o_xy      | out | x_pos, y_pos (kept points)     | valid/ready
//  i_cfg_*   | in  | min/max distance gate writes   | write enable, no wait
//
//  One point per clock sustained while o_xy is ready. Registers in order:
//  gate, multiply, start vector, one per CORDIC step, round.
//  Synchronous active-low reset clears all valid bits and loads the gate
//  defaults (400 and 24000 quarter mm). Each stage loads when it is empty
//  or the stage below it loads, so bubbles squeeze out under an output
//  stall and a new transfer is taken while a result waits at o_xy.
module lidar_point_polar_to_xy #(
    parameter int CORDIC_STAGES = 16   // 8 .. 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    lppxy_pt_if.sink                             i_pt,
    lppxy_xy_if.source                           o_xy,
    input  logic                                 i_cfg_we,
    input  logic [lppxy_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lppxy_pkg::DIST_W-1:0]         i_cfg_data
);

    // Inverse CORDIC gain with a small correction for the stage count, Q32
    localparam logic [63:0] GAIN_FULL = lppxy_pkg::INV_GAIN_C +
        (((lppxy_pkg::INV_GAIN_C * 64'd2) / 64'd3) >> (2 * CORDIC_STAGES));
    localparam logic [lppxy_pkg::GAIN_W-1:0] GAIN = GAIN_FULL[lppxy_pkg::GAIN_W-1:0];

    // range gate registers
    logic [lppxy_pkg::DIST_W-1:0] r_min_dist;
    logic [lppxy_pkg::DIST_W-1:0] r_max_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= lppxy_pkg::MIN_DISTANCE_RST;
            r_max_dist <= lppxy_pkg::MAX_DISTANCE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lppxy_pkg::CFG_MIN_DISTANCE: r_min_dist <= i_cfg_data;
                lppxy_pkg::CFG_MAX_DISTANCE: r_max_dist <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage k input is s_vec[k]; s_en[k] says stage k loads this cycle
    lppxy_pkg::t_vec s_vec   [0:CORDIC_STAGES];
    logic            s_valid [0:CORDIC_STAGES];
    logic            s_en    [0:CORDIC_STAGES];
    logic            front_en;

    lppxy_front #(
        .GAIN (GAIN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_pt.valid),
        .i_angle    (i_pt.angle_code),
        .i_dist     (i_pt.distance_code),
        .i_min_dist (r_min_dist),
        .i_max_dist (r_max_dist),
        .o_en       (front_en),
        .i_down_en  (s_en[0]),
        .o_valid    (s_valid[0]),
        .o_vec      (s_vec[0])
    );

    assign i_pt.ready = front_en;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        lppxy_cordic_stage #(
            .IDX (k)
        ) u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (s_valid[k]),
            .i_vec     (s_vec[k]),
            .o_en      (s_en[k]),
            .i_down_en (s_en[k+1]),
            .o_valid   (s_valid[k+1]),
            .o_vec     (s_vec[k+1])
        );
    end

    // final rounding and output register
    lppxy_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid[CORDIC_STAGES]),
        .i_vec   (s_vec[CORDIC_STAGES]),
        .o_en    (s_en[CORDIC_STAGES]),
        .i_ready (o_xy.ready),
        .o_valid (o_xy.valid),
        .o_x     (o_xy.x_pos),
        .o_y     (o_xy.y_pos)
    );

endmodule

// File: rtl/core/lppxy_front.sv
// Range gate, gain multiply and quadrant start vector (three stages)
module lppxy_front #(
    parameter logic [lppxy_pkg::GAIN_W-1:0] GAIN = 32'h9B74_EDA8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [lppxy_pkg::ANG_W-1:0]  i_angle,
    input  logic [lppxy_pkg::DIST_W-1:0] i_dist,
    input  logic [lppxy_pkg::DIST_W-1:0] i_min_dist,
    input  logic [lppxy_pkg::DIST_W-1:0] i_max_dist,
    output logic                         o_en,
    input  logic                         i_down_en,
    output logic                         o_valid,
    output lppxy_pkg::t_vec              o_vec
);

    // stage A: gate and angle split
    logic                           r_a_valid;
    logic [lppxy_pkg::DIST_W-1:0]   r_a_d;
    logic [1:0]                     r_a_q;
    logic signed [lppxy_pkg::ZW-1:0] r_a_z;
    // stage B: distance times inverse gain
    logic                           r_b_valid;
    logic [lppxy_pkg::P_W-1:0]      r_b_p;
    logic [1:0]                     r_b_q;
    logic signed [lppxy_pkg::ZW-1:0] r_b_z;
    // stage C: start vector
    logic                           r_c_valid;
    lppxy_pkg::t_vec                r_c_vec;
    lppxy_pkg::t_vec                n_c_vec;

    logic                           en_a, en_b, en_c;
    logic                           pass;
    logic [lppxy_pkg::ANG_W-1:0]    shifted;
    logic signed [lppxy_pkg::ZW-1:0] z_start;
    logic signed [lppxy_pkg::XW-1:0] p_ext;

    assign en_c = !r_c_valid || i_down_en;
    assign en_b = !r_b_valid || en_c;
    assign en_a = !r_a_valid || en_b;
    assign o_en = en_a;

    assign pass    = (i_dist > i_min_dist) && (i_dist < i_max_dist);
    // center each quadrant on its axis; residual lies in [-8192, 8191]
    assign shifted = i_angle + 16'd8192;
    assign z_start = {{(lppxy_pkg::ZW - 30){~shifted[13]}}, ~shifted[13], shifted[12:0], 16'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= i_valid && pass;
        end
        if (en_a) begin
            r_a_d <= i_dist;
            r_a_q <= shifted[15:14];
            r_a_z <= z_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid;
        end
        if (en_b) begin
            r_b_p <= r_a_d * GAIN;
            r_b_q <= r_a_q;
            r_b_z <= r_a_z;
        end
    end

    assign p_ext = $signed({{(lppxy_pkg::XW - lppxy_pkg::P_W){1'b0}}, r_b_p});

    always_comb begin
        n_c_vec.z = r_b_z;
        case (r_b_q)
            lppxy_pkg::QUAD_POS_X: begin
                n_c_vec.x = p_ext;
                n_c_vec.y = '0;
            end
            lppxy_pkg::QUAD_POS_Y: begin
                n_c_vec.x = '0;
                n_c_vec.y = p_ext;
            end
            lppxy_pkg::QUAD_NEG_X: begin
                n_c_vec.x = -p_ext;
                n_c_vec.y = '0;
            end
            default: begin
                n_c_vec.x = '0;
                n_c_vec.y = -p_ext;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en_c) begin
            r_c_valid <= r_b_valid;
        end
        if (en_c) begin
            r_c_vec <= n_c_vec;
        end
    end

    assign o_valid = r_c_valid;
    assign o_vec   = r_c_vec;

endmodule

// File: rtl/core/lppxy_cordic_stage.sv
// One registered CORDIC rotation step
module lppxy_cordic_stage #(
    parameter int IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  lppxy_pkg::t_vec i_vec,
    output logic            o_en,
    input  logic            i_down_en,
    output logic            o_valid,
    output lppxy_pkg::t_vec o_vec
);

    localparam logic signed [lppxy_pkg::ZW-1:0] ANG =
        $signed({{(lppxy_pkg::ZW - 32){1'b0}}, lppxy_pkg::atan_turn(IDX)});

    logic                             r_valid;
    lppxy_pkg::t_vec                  r_vec;
    lppxy_pkg::t_vec                  n_vec;
    logic                             en;
    logic signed [lppxy_pkg::XW-1:0]  dx, dy;

    assign en = !r_valid || i_down_en;
    assign dx = i_vec.y >>> IDX;
    assign dy = i_vec.x >>> IDX;

    always_comb begin
        if (!i_vec.z[lppxy_pkg::ZW-1]) begin
            n_vec.x = i_vec.x - dx;
            n_vec.y = i_vec.y + dy;
            n_vec.z = i_vec.z - ANG;
        end else begin
            n_vec.x = i_vec.x + dx;
            n_vec.y = i_vec.y - dy;
            n_vec.z = i_vec.z + ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
        if (en) begin
            r_vec <= n_vec;
        end
    end

    assign o_en    = en;
    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

// File: rtl/core/lppxy_round.sv
// Q32 rounding, saturation and output register
module lppxy_round (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  lppxy_pkg::t_vec                    i_vec,
    output logic                               o_en,
    input  logic                               i_ready,
    output logic                               o_valid,
    output logic signed [lppxy_pkg::OUT_W-1:0] o_x,
    output logic signed [lppxy_pkg::OUT_W-1:0] o_y
);

    logic                                r_valid;
    logic signed [lppxy_pkg::OUT_W-1:0]  r_x, r_y;
    logic signed [lppxy_pkg::OUT_W-1:0]  n_x, n_y;
    logic                                en;

    function automatic logic signed [lppxy_pkg::OUT_W-1:0] finish(
        input logic signed [lppxy_pkg::XW-1:0] v
    );
        logic signed [lppxy_pkg::XW:0]      sum;
        logic signed [lppxy_pkg::RND_W:0]   q;
        logic signed [lppxy_pkg::OUT_W-1:0] res;
        sum = {v[lppxy_pkg::XW-1], v} + ((lppxy_pkg::XW + 1)'(1) <<< 31);
        q   = sum[lppxy_pkg::XW:32];
        if (q > $signed({lppxy_pkg::OUT_LIMIT_POS[lppxy_pkg::RND_W-1],
                         lppxy_pkg::OUT_LIMIT_POS})) begin
            res = lppxy_pkg::OUT_LIMIT_POS[lppxy_pkg::OUT_W-1:0];
        end else if (q < $signed({lppxy_pkg::OUT_LIMIT_NEG[lppxy_pkg::RND_W-1],
                                  lppxy_pkg::OUT_LIMIT_NEG})) begin
            res = lppxy_pkg::OUT_LIMIT_NEG[lppxy_pkg::OUT_W-1:0];
        end else begin
            res = q[lppxy_pkg::OUT_W-1:0];
        end
        return res;
    endfunction

    assign en  = !r_valid || i_ready;
    assign n_x = finish(i_vec.x);
    assign n_y = finish(i_vec.y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
        if (en) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    assign o_en    = en;
    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

// File: rtl/core/lppxy_checker.sv
// Port-level checker for the lidar point converter, with its bind
`include "lidar_point_polar_to_xy_assert.svh"

module lppxy_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [lppxy_pkg::OUT_W-1:0] i_x,
    input logic signed [lppxy_pkg::OUT_W-1:0] i_y
);

    // a result stays offered until taken
    `LPPXY_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // a stalled result keeps its coordinates
    `LPPXY_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_x) && $stable(i_y))

    // saturation keeps coordinates off the most negative code
    `LPPXY_ASSERT_NOW(a_sat_range, i_clk, i_rst_n, i_out_valid, (i_x != 19'sh40000) && (i_y != 19'sh40000))

    // reset empties the pipeline, nothing is offered after it
    `LPPXY_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind lidar_point_polar_to_xy lppxy_checker u_lppxy_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_xy.valid),
    .i_out_ready (o_xy.ready),
    .i_x         (o_xy.x_pos),
    .i_y         (o_xy.y_pos)
);

// File: tb/lidar_point_polar_to_xy_tb.sv
// Self-checking testbench of the lidar polar-to-cartesian point converter
`timescale 1ns / 100ps

module lidar_point_polar_to_xy_tb;

    // ------------------------------------------------------------------
    // Run parameters
    // ------------------------------------------------------------------
    localparam int CORDIC_STAGES  = 16;
    localparam int PIPE_LATENCY   = CORDIC_STAGES + 4;  // registers from input to output
    localparam int WATCHDOG_LIMIT = 2000;               // cycles with no transfer
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_POINTS   = 115;                // about 1150 random points

    typedef logic [lppxy_pkg::DIST_W-1:0] t_dist;
    typedef logic [lppxy_pkg::ANG_W-1:0]  t_ang;

    localparam t_dist GATE_MIN_RST = 18'd400;
    localparam t_dist GATE_MAX_RST = 18'd24000;
    localparam t_dist DIST_TOP     = 18'h3FFFF;

    localparam longint unsigned GAIN_INV_Q32 = 64'h9B74_EDA8;
    localparam longint          XY_CLAMP     = 262143;

    // quadrant that the start vector is rotated into before the CORDIC steps
    typedef enum logic [1:0] {
        START_POS_X = 2'd0,
        START_POS_Y = 2'd1,
        START_NEG_X = 2'd2,
        START_NEG_Y = 2'd3
    } t_start_quad;

    // directed rows either go through the predictor or are known to be gated off
    typedef enum logic {
        ROW_CORDIC    = 1'b0,
        ROW_GATED_OFF = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_dist     gate_min;
        t_dist     gate_max;
        t_ang      angle;
        t_dist     range_q;
        t_row_kind kind;
    } t_pt_row;

    typedef struct packed {
        logic signed [lppxy_pkg::OUT_W-1:0] x;
        logic signed [lppxy_pkg::OUT_W-1:0] y;
    } t_xy_point;

    // atan(2^-i) in turns, 2^32 per turn
    longint atan_q32 [0:23] = '{
        64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
        64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
        64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
        64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA, 64'h0000_517D,
        64'h0000_28BE, 64'h0000_145F, 64'h0000_0A30, 64'h0000_0518,
        64'h0000_028C, 64'h0000_0146, 64'h0000_00A3, 64'h0000_0051
    };

    // Directed corners. Gate changes between groups are written while idle.
    //   default gate: zero distance, both gate edges, quadrant seams
    //   wide open gate: smallest and largest distances, all four axes
    //   crossed gate (equal, then reversed extremes): everything dropped
    t_pt_row directed_rows [0:23] = '{
        '{GATE_MIN_RST, GATE_MAX_RST, 16'd0,     18'd0,      ROW_GATED_OFF},
        '{GATE_MIN_RST, GATE_MAX_RST, 16'd16384, 18'd400,    ROW_GATED_OFF},
        '{GATE_MIN_RST, GATE_MAX_RST, 16'd0,     18'd401,    ROW_CORDIC},
        '{GATE_MIN_RST, GATE_MAX_RST, 16'd65535, 18'd23999,  ROW_CORDIC},
        '{GATE_MIN_RST, GATE_MAX_RST, 16'd32768, 18'd24000,  ROW_GATED_OFF},
        '{GATE_MIN_RST, GATE_MAX_RST, 16'd8191,  18'd12000,  ROW_CORDIC},
        '{GATE_MIN_RST, GATE_MAX_RST, 16'd8192,  18'd12000,  ROW_CORDIC},
        '{GATE_MIN_RST, GATE_MAX_RST, 16'd16384, 18'd12000,  ROW_CORDIC},
        '{GATE_MIN_RST, GATE_MAX_RST, 16'd49152, 18'd20000,  ROW_CORDIC},
        '{GATE_MIN_RST, GATE_MAX_RST, 16'd57343, 18'd5000,   ROW_CORDIC},
        '{GATE_MIN_RST, GATE_MAX_RST, 16'd57344, 18'd5000,   ROW_CORDIC},
        '{18'd0,        DIST_TOP,     16'd0,     18'd0,      ROW_GATED_OFF},
        '{18'd0,        DIST_TOP,     16'd0,     18'd1,      ROW_CORDIC},
        '{18'd0,        DIST_TOP,     16'd0,     18'd262142, ROW_CORDIC},
        '{18'd0,        DIST_TOP,     16'd16384, 18'd262142, ROW_CORDIC},
        '{18'd0,        DIST_TOP,     16'd32768, 18'd262142, ROW_CORDIC},
        '{18'd0,        DIST_TOP,     16'd49152, 18'd262142, ROW_CORDIC},
        '{18'd0,        DIST_TOP,     16'd65535, 18'd262143, ROW_GATED_OFF},
        '{18'd0,        DIST_TOP,     16'd43690, 18'd131071, ROW_CORDIC},
        '{18'd0,        DIST_TOP,     16'd21845, 18'd174762, ROW_CORDIC},
        '{18'd5000,     18'd5000,     16'd100,   18'd5000,   ROW_GATED_OFF},
        '{18'd5000,     18'd5000,     16'd200,   18'd5001,   ROW_GATED_OFF},
        '{DIST_TOP,     18'd0,        16'd65535, 18'd262143, ROW_GATED_OFF},
        '{DIST_TOP,     18'd0,        16'd0,     18'd131072, ROW_GATED_OFF}
    };

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [lppxy_pkg::CFG_IDX_W-1:0]     cfg_idx;
    t_dist                               cfg_data;

    lppxy_pt_if pt_ch ();
    lppxy_xy_if xy_ch ();

    lidar_point_polar_to_xy #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pt       (pt_ch),
        .o_xy       (xy_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state and scoreboard
    // ------------------------------------------------------------------
    t_dist gate_min = GATE_MIN_RST;   // mirrors of the range gate
    t_dist gate_max = GATE_MAX_RST;

    t_xy_point pending_xy [$];    // converted points still to come out

    int  err_count     = 0;
    int  points_sent   = 0;
    int  points_gated  = 0;
    int  points_seen   = 0;
    int  gate_settings = 1;
    int  idle_cycles   = 0;
    bit  send_gaps_on  = 1'b1;    // sender inserts random bubbles
    bit  rx_stall_en   = 1'b1;    // receiver drops ready at random
    int  rx_hold       = 0;

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    // round half up out of Q32, clamp to the output range, keep 19 bits
    function automatic logic signed [lppxy_pkg::OUT_W-1:0] q32_to_out(input longint v);
        longint r;
        r = (v + (longint'(1) << 31)) >>> 32;
        if (r > XY_CLAMP)
            r = XY_CLAMP;
        if (r < -XY_CLAMP)
            r = -XY_CLAMP;
        return r[lppxy_pkg::OUT_W-1:0];
    endfunction

    // Range gate, then CORDIC rotation of (d*G, 0) by the beam angle.
    // Returns 0 when the point is gated off.
    function automatic bit cordic_point(input t_ang ang,
                                        input t_dist range_in,
                                        output t_xy_point pt);
        t_ang             turned;
        t_start_quad      quad;
        longint unsigned  gain;
        longint           p, x, y, z, dx, dy;
        int               i;
        pt = '0;
        if (!(range_in > gate_min && range_in < gate_max))
            return 1'b0;
        // quadrant from the top bits, residual in [-1/8, 1/8) turn
        turned = ang + 16'd8192;
        quad   = t_start_quad'(turned[15:14]);
        z      = (longint'(turned[13:0]) - 8192) * 65536;
        gain   = GAIN_INV_Q32;
        if (2 * CORDIC_STAGES < 64)
            gain += ((GAIN_INV_Q32 * 2) / 3) >> (2 * CORDIC_STAGES);
        p = longint'(64'(range_in) * gain);
        case (quad)
            START_POS_X: begin x = p;  y = 0;  end
            START_POS_Y: begin x = 0;  y = p;  end
            START_NEG_X: begin x = -p; y = 0;  end
            default:     begin x = 0;  y = -p; end
        endcase
        for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_q32[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_q32[i];
            end
        end
        pt.x = q32_to_out(x);
        pt.y = q32_to_out(y);
        return 1'b1;
    endfunction

    // mostly short bubbles, now and then a long one
    function automatic int draw_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Input side: one point per call, predicted at the transfer
    // ------------------------------------------------------------------
    task automatic send_point(input t_ang ang, input t_dist range_in,
                              input bit predicted);
        int        gap;
        t_xy_point pt;
        gap = draw_gap(send_gaps_on);
        @(negedge clk);
        if (gap > 0) begin
            pt_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pt_ch.valid         = 1'b1;
        pt_ch.angle_code    = ang;
        pt_ch.distance_code = range_in;
        do @(posedge clk); while (!pt_ch.ready);
        points_sent++;
        if (predicted && cordic_point(ang, range_in, pt))
            pending_xy = {pending_xy, pt};
        else
            points_gated++;
    endtask

    // stop sending and let every expected point come out
    task automatic drain_points();
        @(negedge clk);
        pt_ch.valid = 1'b0;
        while (pending_xy.size() != 0)
            @(negedge clk);
    endtask

    // dropped points may still be in flight: give the pipe time to empty
    task automatic wait_quiet();
        drain_points();
        repeat (PIPE_LATENCY + 4) @(negedge clk);
    endtask

    task automatic set_gates(input t_dist lo, input t_dist hi);
        wait_quiet();
        cfg_we   = 1'b1;
        cfg_idx  = lppxy_pkg::CFG_MIN_DISTANCE;
        cfg_data = lo;
        @(negedge clk);
        cfg_idx  = lppxy_pkg::CFG_MAX_DISTANCE;
        cfg_data = hi;
        @(negedge clk);
        cfg_we   = 1'b0;
        gate_min = lo;
        gate_max = hi;
        gate_settings++;
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure and the in-order check
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rx_hold != 0) begin
            rx_hold--;
        end else if (!xy_ch.ready || !rx_stall_en) begin
            xy_ch.ready = 1'b1;
            rx_hold     = $urandom_range(0, 8);
        end else begin
            rx_hold     = draw_gap(1'b1);
            xy_ch.ready = (rx_hold == 0);
        end
    end

    always @(posedge clk) begin
        t_xy_point want;
        if (rst_n && xy_ch.valid && xy_ch.ready) begin
            points_seen++;
            if (pending_xy.size() == 0) begin
                report_mismatch($sformatf("unexpected point x=%0d y=%0d",
                                          xy_ch.x_pos, xy_ch.y_pos));
            end else begin
                want = pending_xy.pop_front();
                if (xy_ch.x_pos !== want.x)
                    report_mismatch($sformatf("x_pos %0d, expected %0d",
                                              xy_ch.x_pos, want.x));
                if (xy_ch.y_pos !== want.y)
                    report_mismatch($sformatf("y_pos %0d, expected %0d",
                                              xy_ch.y_pos, want.y));
            end
        end
    end

    // no transfer on either channel for too long means the block is stuck
    always @(posedge clk) begin
        if ((pt_ch.valid && pt_ch.ready) || (xy_ch.valid && xy_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d cycles without a transfer, %0d points pending",
                     idle_cycles, pending_xy.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int    row;
        int    phase;
        int    n;
        int    pause_at;
        int    r;
        t_dist lo, hi, d;
        t_ang  a;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = lppxy_pkg::CFG_MIN_DISTANCE;
        cfg_data            = '0;
        pt_ch.valid         = 1'b0;
        pt_ch.angle_code    = '0;
        pt_ch.distance_code = '0;
        xy_ch.ready         = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed corners; the first group runs on the reset gate
        for (row = 0; row < 24; row++) begin
            if (directed_rows[row].gate_min != gate_min ||
                directed_rows[row].gate_max != gate_max)
                set_gates(directed_rows[row].gate_min, directed_rows[row].gate_max);
            send_point(directed_rows[row].angle, directed_rows[row].range_q,
                       directed_rows[row].kind == ROW_CORDIC);
        end

        // random phases, each with its own gate and idling mix
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin lo = GATE_MIN_RST; hi = GATE_MAX_RST; end
                1: begin lo = 18'd0;        hi = DIST_TOP;     end
                5: begin                                       // crossed gate
                    hi = t_dist'($urandom_range(0, 200000));
                    lo = t_dist'(hi + $urandom_range(0, 1000));
                end
                7: begin                                       // one-value window
                    lo = t_dist'($urandom_range(0, 260000));
                    hi = lo + 18'd2;
                end
                default: begin
                    lo = t_dist'($urandom_range(0, 200000));
                    hi = t_dist'(lo + $urandom_range(1, 262143 - lo));
                end
            endcase
            set_gates(lo, hi);
            // phase 1 runs with no bubbles on either side
            send_gaps_on = (phase % 3 != 1);
            rx_stall_en  = (phase % 4 != 1);
            pause_at     = $urandom_range(10, PHASE_POINTS - 10);

            for (n = 0; n < PHASE_POINTS; n++) begin
                if (n == pause_at)
                    drain_points();
                r = $urandom_range(0, 99);
                if (r < 75 && hi > lo + 18'd1)
                    d = t_dist'($urandom_range(lo + 1, hi - 1));
                else if (r < 88)
                    case ($urandom_range(0, 3))
                        0:       d = lo;
                        1:       d = lo + 18'd1;
                        2:       d = hi - 18'd1;
                        default: d = hi;
                    endcase
                else
                    d = t_dist'($urandom_range(0, 262143));
                // some angles sit right on a quadrant seam
                if ($urandom_range(0, 99) < 80)
                    a = t_ang'($urandom_range(0, 65535));
                else
                    a = 16'($urandom_range(0, 3) * 16384 + 8192 + $urandom_range(0, 8) - 4);
                send_point(a, d, 1'b1);
            end
        end

        wait_quiet();
        while (pending_xy.size() != 0) begin
            void'(pending_xy.pop_front());
            report_mismatch("converted point never came out");
        end

        $display("summary: %0d points sent over %0d gate settings, %0d gated off",
                 points_sent, gate_settings, points_gated);
        $display("summary: %0d cartesian points checked, %0d mismatches",
                 points_seen, err_count);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
